// ===== design/assert_macros.svh =====
// Assertion helpers used by the top design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define CYL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CYL_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cyl_pkg.sv =====
`default_nettype none

package cyl_pkg;

    localparam int SQRT_STAGES = 48;
    localparam int RAD_W       = 2 * SQRT_STAGES;
    localparam int REM_W       = SQRT_STAGES + 2;
    localparam int DIV_STAGES  = 32;
    localparam int DEN_W       = 64;
    localparam int LANES       = 4;

    localparam int LANE_FAR  = 0;
    localparam int LANE_NEAR = 1;
    localparam int LANE_CAP  = 2;
    localparam int LANE_BASE = 3;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_in;

    typedef struct packed {
        logic               any_hit;
        logic               side_far_valid;
        logic signed [31:0] side_far_dist;
        logic               side_near_valid;
        logic signed [31:0] side_near_dist;
        logic               cap_valid;
        logic signed [31:0] cap_dist;
        logic               base_valid;
        logic signed [31:0] base_dist;
    } t_out;

    // Per-ray sideband carried alongside the long arithmetic units.
    typedef struct packed {
        t_in                ray;
        logic [63:0]        a;
        logic signed [65:0] nb;
        logic               side_hit;
        logic               disc_en;
    } t_band;

    // Truncated quotient magnitude -> signed Q16.16 with saturation.
    function automatic logic signed [31:0] sat_q(input logic ovf, input logic neg,
                                                 input logic [31:0] quo);
        logic signed [31:0] res;
        if (ovf) begin
            res = neg ? Q_MIN : Q_MAX;
        end else if (!neg) begin
            res = quo[31] ? Q_MAX : $signed(quo);
        end else if (quo > 32'h8000_0000) begin
            res = Q_MIN;
        end else begin
            res = $signed(32'h0 - quo);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/cyl_sqrt.sv =====
`default_nettype none

// Digit-by-digit integer square root, one result bit per register stage.
module cyl_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [cyl_pkg::RAD_W-1:0]     i_x,
    output logic [cyl_pkg::SQRT_STAGES-1:0]    o_root
);

    localparam int N  = cyl_pkg::SQRT_STAGES;
    localparam int XW = cyl_pkg::RAD_W;
    localparam int RW = cyl_pkg::REM_W;

    logic [XW-1:0] r_x    [N];
    logic [RW-1:0] r_rem  [N];
    logic [N-1:0]  r_root [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [XW-1:0] x_in;
        logic [RW-1:0] rem_in;
        logic [N-1:0]  root_in;
        logic [RW+1:0] acc;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          take;

        if (g == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        assign acc   = {rem_in, x_in[XW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = acc - trial;
        assign take  = (acc >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= {x_in[XW-3:0], 2'b00};
                r_rem[g]  <= take ? diff[RW-1:0] : acc[RW-1:0];
                r_root[g] <= {root_in[N-2:0], take};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

`default_nettype wire

// ===== design/cyl_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per register stage.
// The starting remainder must be below the divisor.
module cyl_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [cyl_pkg::DEN_W-1:0]     i_rem,
    input  wire logic [cyl_pkg::DIV_STAGES-1:0] i_low,
    input  wire logic [cyl_pkg::DEN_W-1:0]     i_den,
    output logic [cyl_pkg::DIV_STAGES-1:0]     o_quo
);

    localparam int N  = cyl_pkg::DIV_STAGES;
    localparam int DW = cyl_pkg::DEN_W;

    logic [DW-1:0] r_rem [N];
    logic [N-1:0]  r_low [N];
    logic [DW-1:0] r_den [N];
    logic [N-1:0]  r_quo [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [N-1:0]  low_in;
        logic [DW-1:0] den_in;
        logic [N-1:0]  quo_in;
        logic [DW-1:0] trial;
        logic          take;

        if (g == 0) begin : g_first
            assign rem_in = i_rem;
            assign low_in = i_low;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign low_in = r_low[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        assign trial = {rem_in[DW-2:0], low_in[N-1]};
        assign take  = (trial >= den_in);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= take ? (trial - den_in) : trial;
                r_low[g] <= {low_in[N-2:0], 1'b0};
                r_den[g] <= den_in;
                r_quo[g] <= {quo_in[N-2:0], take};
            end
        end
    end

    assign o_quo = r_quo[N-1];

endmodule

`default_nettype wire

// ===== design/ray_unit_cylinder_intersect_top.sv =====
`default_nettype none
// Ray against the canonical capped cylinder (radius 1, z from 0 to 1), Q16.16.
// Input channel: i_in_valid / o_in_stall with one ray per transaction
//   (origin and direction in cylinder space).
// Output channel: o_out_valid / i_out_stall with one result per ray:
//   two side roots, cap and base plane distances, each with a valid flag.
// Configuration: i_cfg_we writes i_cfg_wdata into epsilon; write only while idle.
// Throughput: one ray per cycle; a new ray is taken every cycle that the
//   output is not stalled.
// Pipeline: the 48-stage square root and the 32-stage dividers, one bit
//   per stage, plus ten multiply/add stages around them, lie between the
//   accepting edge and the result on the outputs.
// Stall: while the output holds a result and i_out_stall is high, the whole
//   pipeline freezes and o_in_stall is high; nothing is dropped or repeated.
// Reset: i_rst_n (synchronous, active low) empties the pipeline and sets
//   epsilon to 1.
`include "assert_macros.svh"

module ray_unit_cylinder_intersect_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire cyl_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output cyl_pkg::t_out       o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_wdata
);

    localparam int NSQ = cyl_pkg::SQRT_STAGES;
    localparam int NDV = cyl_pkg::DIV_STAGES;
    localparam int NL  = cyl_pkg::LANES;

    logic        pipe_en;
    logic [15:0] r_eps;

    // stage valids
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_g_v, r_h_v, r_i_v, r_j_v, r_k_v;
    logic r_sq_v [NSQ];
    logic r_dv_v [NDV];

    // A: input register
    cyl_pkg::t_in r_a_ray;

    // B: products
    cyl_pkg::t_in       r_b_ray;
    logic signed [63:0] r_b_pxx, r_b_pyy, r_b_k1, r_b_k2, r_b_b1, r_b_b2;

    // C: a, cross term, -b
    cyl_pkg::t_in       r_c_ray, n_c_ray;
    logic [63:0]        r_c_a, n_c_a;
    logic [47:0]        r_c_k, n_c_k;
    logic signed [65:0] r_c_nb, n_c_nb;
    logic               r_c_side_ok, n_c_side_ok;
    logic               r_c_disc_en, n_c_disc_en;
    logic signed [64:0] c_kd;
    logic [64:0]        c_km;
    logic signed [65:0] c_bs;
    logic [31:0]        c_dzm;

    // D: partial products of k^2
    cyl_pkg::t_in       r_d_ray;
    logic [63:0]        r_d_a;
    logic signed [65:0] r_d_nb;
    logic               r_d_side_ok, r_d_disc_en;
    logic [47:0]        r_d_hh, r_d_hl, r_d_ll;

    // E: discriminant
    cyl_pkg::t_band     r_e_band, n_e_band;
    logic [95:0]        r_e_delta, n_e_delta;
    logic [95:0]        e_k2, e_a32;

    cyl_pkg::t_band     r_sq_band [NSQ];
    logic [NSQ-1:0]     sq_root;

    // F: divider set-up
    cyl_pkg::t_band     r_f_band;
    logic [63:0]        r_f_rem [NL], n_f_rem [NL];
    logic [31:0]        r_f_low [NL], n_f_low [NL];
    logic [63:0]        r_f_den [NL], n_f_den [NL];
    logic [NL-1:0]      r_f_ovf, n_f_ovf, r_f_neg, n_f_neg;
    logic signed [66:0] f_num [2];
    logic [66:0]        f_nm [2];
    logic signed [33:0] f_dn [2];
    logic [33:0]        f_dm [2];
    logic [31:0]        f_dzm;

    cyl_pkg::t_band     r_dv_band [NDV];
    logic [NL-1:0]      r_dv_ovf [NDV], r_dv_neg [NDV];
    logic [31:0]        dv_quo [NL];

    // G: saturated distances
    cyl_pkg::t_band     r_g_band;
    logic signed [31:0] r_g_t [NL];

    // H: products for hit-point checks
    cyl_pkg::t_band     r_h_band;
    logic signed [31:0] r_h_t [NL];
    logic signed [63:0] r_h_p [6];

    // I: hit z and disc coordinates
    cyl_pkg::t_band     r_i_band;
    logic signed [31:0] r_i_t [NL];
    logic [1:0]         r_i_zok, n_i_zok;
    logic [3:0]         r_i_small, n_i_small;
    logic [32:0]        r_i_pm [4], n_i_pm [4];
    logic signed [64:0] i_oxb, i_oyb, i_ozb;
    logic signed [64:0] i_z [2];
    logic signed [64:0] i_pc [4];
    logic [64:0]        i_pmag [4];

    // J: squares
    cyl_pkg::t_band     r_j_band;
    logic signed [31:0] r_j_t [NL];
    logic [1:0]         r_j_zok;
    logic [3:0]         r_j_small;
    logic [65:0]        r_j_sq [4];

    // K: output
    cyl_pkg::t_out      r_k_out, n_k_out;
    logic [66:0]        k_s1, k_s0;
    logic               k_in1, k_in0;

    assign pipe_en     = !(r_k_v && i_out_stall);
    assign o_in_stall  = !pipe_en;
    assign o_out_valid = r_k_v;
    assign o_out_data  = r_k_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 16'd1;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0; r_b_v <= 1'b0; r_c_v <= 1'b0; r_d_v <= 1'b0;
            r_e_v <= 1'b0; r_f_v <= 1'b0; r_g_v <= 1'b0; r_h_v <= 1'b0;
            r_i_v <= 1'b0; r_j_v <= 1'b0; r_k_v <= 1'b0;
            for (int s = 0; s < NSQ; s++) r_sq_v[s] <= 1'b0;
            for (int s = 0; s < NDV; s++) r_dv_v[s] <= 1'b0;
        end else if (pipe_en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_sq_v[0] <= r_e_v;
            for (int s = 1; s < NSQ; s++) r_sq_v[s] <= r_sq_v[s-1];
            r_f_v <= r_sq_v[NSQ-1];
            r_dv_v[0] <= r_f_v;
            for (int s = 1; s < NDV; s++) r_dv_v[s] <= r_dv_v[s-1];
            r_g_v <= r_dv_v[NDV-1];
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
            r_k_v <= r_j_v;
        end
    end

    // C: a = dx^2+dy^2, k = |ox*dy - oy*dx|, nb = -(ox*dx + oy*dy)
    always_comb begin
        n_c_ray     = r_b_ray;
        n_c_a       = $unsigned(r_b_pxx) + $unsigned(r_b_pyy);
        c_kd        = {r_b_k1[63], r_b_k1} - {r_b_k2[63], r_b_k2};
        c_km        = c_kd[64] ? $unsigned(-c_kd) : $unsigned(c_kd);
        n_c_k       = c_km[47:0];
        c_bs        = {{2{r_b_b1[63]}}, r_b_b1} + {{2{r_b_b2[63]}}, r_b_b2};
        n_c_nb      = -c_bs;
        n_c_side_ok = (n_c_a > {32'd0, r_eps, 16'd0}) && (c_km[64:48] == '0);
        c_dzm       = r_b_ray.dir_z[31] ? (32'd0 - r_b_ray.dir_z) : r_b_ray.dir_z;
        n_c_disc_en = (c_dzm > {16'd0, r_eps});
    end

    // E: delta = a*2^32 - k^2
    always_comb begin
        e_k2      = {r_d_hh, 48'd0} + {23'd0, r_d_hl, 25'd0} + {48'd0, r_d_ll};
        e_a32     = {r_d_a, 32'd0};
        n_e_delta = e_a32 - e_k2;
        n_e_band.ray      = r_d_ray;
        n_e_band.a        = r_d_a;
        n_e_band.nb       = r_d_nb;
        n_e_band.side_hit = r_d_side_ok && (e_a32 >= e_k2);
        n_e_band.disc_en  = r_d_disc_en;
    end

    cyl_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_x    (r_e_delta),
        .o_root (sq_root)
    );

    // F: roots (-b +/- s) / a and plane distances, split into quotient set-up
    always_comb begin
        f_num[0] = {r_sq_band[NSQ-1].nb[65], r_sq_band[NSQ-1].nb} + {19'd0, sq_root};
        f_num[1] = {r_sq_band[NSQ-1].nb[65], r_sq_band[NSQ-1].nb} - {19'd0, sq_root};
        for (int l = 0; l < 2; l++) begin
            f_nm[l]    = f_num[l][66] ? $unsigned(-f_num[l]) : $unsigned(f_num[l]);
            n_f_rem[l] = {13'd0, f_nm[l][66:16]};
            n_f_low[l] = {f_nm[l][15:0], 16'd0};
            n_f_den[l] = r_sq_band[NSQ-1].a;
            n_f_ovf[l] = ({13'd0, f_nm[l][66:16]} >= r_sq_band[NSQ-1].a);
            n_f_neg[l] = f_num[l][66];
        end
        f_dzm = r_sq_band[NSQ-1].ray.dir_z[31] ? (32'd0 - r_sq_band[NSQ-1].ray.dir_z)
                                               : r_sq_band[NSQ-1].ray.dir_z;
        // cap: (1 - oz) / dz, base: (0 - oz) / dz, numerators scaled by 2^16
        f_dn[0] = 34'h1_0000 - {{2{r_sq_band[NSQ-1].ray.origin_z[31]}},
                                r_sq_band[NSQ-1].ray.origin_z};
        f_dn[1] = 34'd0 - {{2{r_sq_band[NSQ-1].ray.origin_z[31]}},
                           r_sq_band[NSQ-1].ray.origin_z};
        for (int l = 0; l < 2; l++) begin
            f_dm[l]      = f_dn[l][33] ? $unsigned(-f_dn[l]) : $unsigned(f_dn[l]);
            n_f_rem[l+2] = {46'd0, f_dm[l][33:16]};
            n_f_low[l+2] = {f_dm[l][15:0], 16'd0};
            n_f_den[l+2] = {32'd0, f_dzm};
            n_f_ovf[l+2] = ({14'd0, f_dm[l][33:16]} >= f_dzm);
            n_f_neg[l+2] = f_dn[l][33] ^ r_sq_band[NSQ-1].ray.dir_z[31];
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
        cyl_div u_div (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_rem (r_f_rem[l]),
            .i_low (r_f_low[l]),
            .i_den (r_f_den[l]),
            .o_quo (dv_quo[l])
        );
    end

    // I: side hit z in [0,1] and disc hit coordinates
    always_comb begin
        i_ozb = {{17{r_h_band.ray.origin_z[31]}}, r_h_band.ray.origin_z, 16'd0};
        i_oxb = {{17{r_h_band.ray.origin_x[31]}}, r_h_band.ray.origin_x, 16'd0};
        i_oyb = {{17{r_h_band.ray.origin_y[31]}}, r_h_band.ray.origin_y, 16'd0};
        for (int l = 0; l < 2; l++) begin
            i_z[l]     = i_ozb + {r_h_p[l][63], r_h_p[l]};
            n_i_zok[l] = !i_z[l][64] && (i_z[l][63:0] <= 64'h1_0000_0000);
        end
        i_pc[0] = i_oxb + {r_h_p[2][63], r_h_p[2]};
        i_pc[1] = i_oyb + {r_h_p[3][63], r_h_p[3]};
        i_pc[2] = i_oxb + {r_h_p[4][63], r_h_p[4]};
        i_pc[3] = i_oyb + {r_h_p[5][63], r_h_p[5]};
        for (int l = 0; l < 4; l++) begin
            i_pmag[l]    = i_pc[l][64] ? $unsigned(-i_pc[l]) : $unsigned(i_pc[l]);
            n_i_small[l] = (i_pmag[l] <= 65'h1_0000_0000);
            n_i_pm[l]    = i_pmag[l][32:0];
        end
    end

    // K: disc test x^2 + y^2 <= 1 and result assembly
    always_comb begin
        k_s1  = {1'b0, r_j_sq[0]} + {1'b0, r_j_sq[1]};
        k_s0  = {1'b0, r_j_sq[2]} + {1'b0, r_j_sq[3]};
        k_in1 = r_j_band.disc_en && r_j_small[0] && r_j_small[1]
                && (k_s1 <= 67'h1_0000_0000_0000_0000);
        k_in0 = r_j_band.disc_en && r_j_small[2] && r_j_small[3]
                && (k_s0 <= 67'h1_0000_0000_0000_0000);
        n_k_out.any_hit         = r_j_band.side_hit || k_in1 || k_in0;
        n_k_out.side_far_valid  = r_j_band.side_hit && r_j_zok[0];
        n_k_out.side_far_dist   = n_k_out.side_far_valid ? r_j_t[cyl_pkg::LANE_FAR] : '0;
        n_k_out.side_near_valid = r_j_band.side_hit && r_j_zok[1];
        n_k_out.side_near_dist  = n_k_out.side_near_valid ? r_j_t[cyl_pkg::LANE_NEAR] : '0;
        n_k_out.cap_valid       = k_in1;
        n_k_out.cap_dist        = k_in1 ? r_j_t[cyl_pkg::LANE_CAP] : '0;
        n_k_out.base_valid      = k_in0;
        n_k_out.base_dist       = k_in0 ? r_j_t[cyl_pkg::LANE_BASE] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_ray <= i_in_data;

            r_b_ray <= r_a_ray;
            r_b_pxx <= r_a_ray.dir_x * r_a_ray.dir_x;
            r_b_pyy <= r_a_ray.dir_y * r_a_ray.dir_y;
            r_b_k1  <= r_a_ray.origin_x * r_a_ray.dir_y;
            r_b_k2  <= r_a_ray.origin_y * r_a_ray.dir_x;
            r_b_b1  <= r_a_ray.origin_x * r_a_ray.dir_x;
            r_b_b2  <= r_a_ray.origin_y * r_a_ray.dir_y;

            r_c_ray     <= n_c_ray;
            r_c_a       <= n_c_a;
            r_c_k       <= n_c_k;
            r_c_nb      <= n_c_nb;
            r_c_side_ok <= n_c_side_ok;
            r_c_disc_en <= n_c_disc_en;

            // k^2 from k split into 24-bit halves
            r_d_ray     <= r_c_ray;
            r_d_a       <= r_c_a;
            r_d_nb      <= r_c_nb;
            r_d_side_ok <= r_c_side_ok;
            r_d_disc_en <= r_c_disc_en;
            r_d_hh      <= r_c_k[47:24] * r_c_k[47:24];
            r_d_hl      <= r_c_k[47:24] * r_c_k[23:0];
            r_d_ll      <= r_c_k[23:0] * r_c_k[23:0];

            r_e_band  <= n_e_band;
            r_e_delta <= n_e_delta;

            r_sq_band[0] <= r_e_band;
            for (int s = 1; s < NSQ; s++) r_sq_band[s] <= r_sq_band[s-1];

            r_f_band <= r_sq_band[NSQ-1];
            r_f_ovf  <= n_f_ovf;
            r_f_neg  <= n_f_neg;
            for (int l = 0; l < NL; l++) begin
                r_f_rem[l] <= n_f_rem[l];
                r_f_low[l] <= n_f_low[l];
                r_f_den[l] <= n_f_den[l];
            end

            r_dv_band[0] <= r_f_band;
            r_dv_ovf[0]  <= r_f_ovf;
            r_dv_neg[0]  <= r_f_neg;
            for (int s = 1; s < NDV; s++) begin
                r_dv_band[s] <= r_dv_band[s-1];
                r_dv_ovf[s]  <= r_dv_ovf[s-1];
                r_dv_neg[s]  <= r_dv_neg[s-1];
            end

            r_g_band <= r_dv_band[NDV-1];
            for (int l = 0; l < NL; l++) begin
                r_g_t[l] <= cyl_pkg::sat_q(r_dv_ovf[NDV-1][l], r_dv_neg[NDV-1][l],
                                           dv_quo[l]);
            end

            r_h_band <= r_g_band;
            r_h_t    <= r_g_t;
            r_h_p[0] <= r_g_t[cyl_pkg::LANE_FAR]  * r_g_band.ray.dir_z;
            r_h_p[1] <= r_g_t[cyl_pkg::LANE_NEAR] * r_g_band.ray.dir_z;
            r_h_p[2] <= r_g_t[cyl_pkg::LANE_CAP]  * r_g_band.ray.dir_x;
            r_h_p[3] <= r_g_t[cyl_pkg::LANE_CAP]  * r_g_band.ray.dir_y;
            r_h_p[4] <= r_g_t[cyl_pkg::LANE_BASE] * r_g_band.ray.dir_x;
            r_h_p[5] <= r_g_t[cyl_pkg::LANE_BASE] * r_g_band.ray.dir_y;

            r_i_band  <= r_h_band;
            r_i_t     <= r_h_t;
            r_i_zok   <= n_i_zok;
            r_i_small <= n_i_small;
            r_i_pm    <= n_i_pm;

            r_j_band  <= r_i_band;
            r_j_t     <= r_i_t;
            r_j_zok   <= r_i_zok;
            r_j_small <= r_i_small;
            for (int l = 0; l < 4; l++) r_j_sq[l] <= r_i_pm[l] * r_i_pm[l];

            r_k_out <= n_k_out;
        end
    end

    `CYL_ASSERT(a_any_hit, i_clk, i_rst_n, o_out_valid |-> (o_out_data.any_hit || !(o_out_data.side_far_valid || o_out_data.side_near_valid || o_out_data.cap_valid || o_out_data.base_valid)), "hit flag without any_hit")
    `CYL_ASSERT(a_zero_dist, i_clk, i_rst_n, o_out_valid |-> ((o_out_data.cap_valid || o_out_data.cap_dist == 32'sd0) && (o_out_data.base_valid || o_out_data.base_dist == 32'sd0) && (o_out_data.side_far_valid || o_out_data.side_far_dist == 32'sd0) && (o_out_data.side_near_valid || o_out_data.side_near_dist == 32'sd0)), "invalid distance not zero")
    `CYL_ASSERT(a_cfg_write, i_clk, i_rst_n, i_cfg_we |=> (r_eps == $past(i_cfg_wdata)), "epsilon write lost")
    `CYL_ASSERT(a_freeze, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> ($stable(r_j_v) && $stable(r_a_v)), "pipeline moved during stall")
    `CYL_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

`default_nettype wire

// ===== bench/cyl_hit_checker.sv =====
`default_nettype none

module cyl_hit_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_stall,
    input  wire cyl_pkg::t_in  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire cyl_pkg::t_out i_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata,
    output int                 o_errors,
    output int                 o_pending
);

    typedef logic signed [129:0] t_wide;

    logic [15:0]   eps_q;
    cyl_pkg::t_out pending_hits[$];
    int            n_err;

    assign o_errors  = n_err;
    assign o_pending = pending_hits.size();

    function automatic logic [47:0] isqrt96(logic [95:0] x);
        logic [95:0] r;
        logic [95:0] c;
        r = '0;
        for (int i = 47; i >= 0; i--) begin
            c = r | (96'd1 << i);
            if (c * c <= x) r = c;
        end
        return r[47:0];
    endfunction

    function automatic t_wide sat32(t_wide v);
        if (v > t_wide'(64'sh7FFF_FFFF)) return t_wide'(64'sh7FFF_FFFF);
        if (v < -t_wide'(64'sh8000_0000)) return -t_wide'(64'sh8000_0000);
        return v;
    endfunction

    // (num << 16) / a, truncated toward zero, saturated to Q16.16
    function automatic longint side_root(t_wide num, logic [63:0] a);
        logic [129:0] m;
        logic [129:0] q;
        t_wide        sq;
        m = (num < 0) ? -num : num;
        if ((m >> 111) != 0) return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
        q = (m << 16) / {66'd0, a};
        sq = $signed(q);
        if (num < 0) sq = -sq;
        return longint'(sat32(sq));
    endfunction

    function automatic bit in_unit_disc(longint ox, longint oy, longint dx, longint dy,
                                        longint d);
        t_wide px;
        t_wide py;
        px = ox * 65536 + d * dx;
        py = oy * 65536 + d * dy;
        return (px * px + py * py) <= (t_wide'(1) <<< 64);
    endfunction

    function automatic cyl_pkg::t_out predict_hits(cyl_pkg::t_in r, logic [15:0] eps);
        cyl_pkg::t_out res;
        longint        ox, oy, oz, dx, dy, dz, tf, tn, zf, zn, d1, d0;
        logic [63:0]   mx, my, mz, a;
        t_wide         wox, woy, wdx, wdy, k, km, nb, ws;
        logic [95:0]   a32, k2;
        res = '0;
        ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
        dx = r.dir_x;    dy = r.dir_y;    dz = r.dir_z;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        mz = (dz < 0) ? -dz : dz;
        a  = mx * mx + my * my;
        if (a > ({48'd0, eps} << 16)) begin
            wox = ox; woy = oy; wdx = dx; wdy = dy;
            k  = wox * wdy - woy * wdx;
            km = (k < 0) ? -k : k;
            if (km < (t_wide'(1) <<< 48)) begin
                k2  = km[95:0] * km[95:0];
                a32 = {a, 32'd0};
                if (a32 >= k2) begin
                    ws = {82'd0, isqrt96(a32 - k2)};
                    nb = -(wox * wdx + woy * wdy);
                    tf = side_root(nb + ws, a);
                    tn = side_root(nb - ws, a);
                    zf = oz * 65536 + tf * dz;
                    zn = oz * 65536 + tn * dz;
                    res.any_hit = 1'b1;
                    if (zf >= 0 && zf <= (64'sd1 <<< 32)) begin
                        res.side_far_valid = 1'b1;
                        res.side_far_dist  = tf[31:0];
                    end
                    if (zn >= 0 && zn <= (64'sd1 <<< 32)) begin
                        res.side_near_valid = 1'b1;
                        res.side_near_dist  = tn[31:0];
                    end
                end
            end
        end
        if (mz > {48'd0, eps}) begin
            d1 = longint'(sat32(t_wide'(((65536 - oz) * 65536) / dz)));
            d0 = longint'(sat32(t_wide'(((0 - oz) * 65536) / dz)));
            if (in_unit_disc(ox, oy, dx, dy, d1)) begin
                res.cap_valid = 1'b1;
                res.cap_dist  = d1[31:0];
                res.any_hit   = 1'b1;
            end
            if (in_unit_disc(ox, oy, dx, dy, d0)) begin
                res.base_valid = 1'b1;
                res.base_dist  = d0[31:0];
                res.any_hit    = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        n_err++;
    endtask

    always @(posedge i_clk) begin
        cyl_pkg::t_out want;
        if (!i_rst_n) begin
            eps_q = 16'd1;
            pending_hits.delete();
        end else begin
            if (i_cfg_we) eps_q = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) pending_hits.push_back(predict_hits(i_in_data, eps_q));
            if (i_out_valid && !i_out_stall) begin
                if (pending_hits.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = pending_hits.pop_front();
                    if (i_out_data.any_hit !== want.any_hit)
                        report_mismatch("any_hit", i_out_data.any_hit, want.any_hit);
                    if (i_out_data.side_far_valid !== want.side_far_valid)
                        report_mismatch("side_far_valid", i_out_data.side_far_valid,
                                        want.side_far_valid);
                    if (i_out_data.side_far_dist !== want.side_far_dist)
                        report_mismatch("side_far_dist", i_out_data.side_far_dist,
                                        want.side_far_dist);
                    if (i_out_data.side_near_valid !== want.side_near_valid)
                        report_mismatch("side_near_valid", i_out_data.side_near_valid,
                                        want.side_near_valid);
                    if (i_out_data.side_near_dist !== want.side_near_dist)
                        report_mismatch("side_near_dist", i_out_data.side_near_dist,
                                        want.side_near_dist);
                    if (i_out_data.cap_valid !== want.cap_valid)
                        report_mismatch("cap_valid", i_out_data.cap_valid, want.cap_valid);
                    if (i_out_data.cap_dist !== want.cap_dist)
                        report_mismatch("cap_dist", i_out_data.cap_dist, want.cap_dist);
                    if (i_out_data.base_valid !== want.base_valid)
                        report_mismatch("base_valid", i_out_data.base_valid, want.base_valid);
                    if (i_out_data.base_dist !== want.base_dist)
                        report_mismatch("base_dist", i_out_data.base_dist, want.base_dist);
                end
            end
        end
    end

    initial n_err = 0;

endmodule

`default_nettype wire

// ===== bench/tb_ray_unit_cylinder_intersect_top.sv =====
`default_nettype none

module tb_ray_unit_cylinder_intersect_top;

    localparam int ONE = 65536;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    cyl_pkg::t_in  in_data = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    cyl_pkg::t_out out_data;
    logic          cfg_we = 1'b0;
    logic [15:0]   cfg_wdata = '0;
    int            n_errors;
    int            n_pending;
    bit            quiet = 0;
    bit            hold_req = 0;
    int            idle_cycles = 0;

    ray_unit_cylinder_intersect_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    cyl_hit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stall, quiet stretches, one long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            out_stall <= 1'b1;
            repeat (400) @(posedge i_clk);
            hold_req = 0;
        end else begin
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
        end
    end

    // no transaction on either channel for too long ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("tb_ray_unit_cylinder_intersect_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_ray(cyl_pkg::t_in r);
        while (!quiet && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic send_vec(int ox, int oy, int oz, int dx, int dy, int dz);
        cyl_pkg::t_in r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        send_ray(r);
    endtask

    // drain, let the pipeline empty, then write epsilon
    task automatic set_epsilon(logic [15:0] v);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int rnd_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic random_rays(int n);
        cyl_pkg::t_in r;
        int           sc;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 25) begin
                r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end else begin
                sc = 1 << $urandom_range(17, 8);
                r.origin_x = rnd_in(-2 * ONE, 2 * ONE);
                r.origin_y = rnd_in(-2 * ONE, 2 * ONE);
                r.origin_z = rnd_in(-ONE, 2 * ONE);
                r.dir_x = rnd_in(-sc, sc);
                r.dir_y = rnd_in(-sc, sc);
                r.dir_z = ($urandom_range(9) == 0) ? 0 : rnd_in(-sc, sc);
                // aim through the cylinder interior now and then
                if ($urandom_range(3) == 0) begin
                    r.dir_x = rnd_in(-ONE / 2, ONE / 2) - r.origin_x;
                    r.dir_y = rnd_in(-ONE / 2, ONE / 2) - r.origin_y;
                    r.dir_z = rnd_in(0, ONE) - r.origin_z;
                end
            end
            send_ray(r);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: side, axis, tangent, flat, threshold and extreme rays
        send_vec(-2 * ONE, 0, ONE / 2, ONE, 0, 0);
        send_vec(0, 0, -ONE, 0, 0, ONE);
        send_vec(0, 0, 2 * ONE, 0, 0, -ONE);
        send_vec(ONE, -2 * ONE, ONE / 2, 0, ONE, 0);
        send_vec(ONE + 1, -2 * ONE, ONE / 2, 0, ONE, 0);
        send_vec(0, 0, ONE / 2, 0, 0, 0);
        send_vec(0, 0, ONE / 2, 0, 0, 1);
        send_vec(0, 0, ONE / 2, 0, 0, 2);
        send_vec(0, 0, ONE / 2, 1, 0, -2);
        send_vec(ONE, 0, 0, 0, 0, ONE);
        send_vec(0, 0, ONE, ONE, 0, 0);
        send_vec(-2 * ONE, 0, 0, ONE, 0, ONE);
        send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(0, 0, ONE / 2, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_vec(0, 0, 0, 1, 0, 32'h8000_0000);
        send_vec(ONE / 2, ONE / 2, ONE / 2, -3, 5, 7);
        send_vec(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE);
        send_vec(0, 0, 32'h7FFF_FFFF, 0, 0, -1);
        send_vec(0, 0, ONE / 2, 1 << 20, 1 << 20, 0);
        random_rays(180);

        set_epsilon(16'd0);
        quiet = 1;
        random_rays(200);
        quiet = 0;

        set_epsilon(16'hFFFF);
        hold_req = 1;
        random_rays(200);

        set_epsilon(16'($urandom_range(2, 65534)));
        random_rays(250);

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) $display("tb_ray_unit_cylinder_intersect_top: PASS");
        else $display("tb_ray_unit_cylinder_intersect_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
